// ===== rtl/sagu_pkg.sv =====
// ----------------------------------------------------------------------------
// sagu_pkg
// Shared types and constants for the step sequenced audio gate.
// ----------------------------------------------------------------------------
package sagu_pkg;

  localparam int STEP_COUNT  = 32;
  localparam int STEP_W      = $clog2(STEP_COUNT);
  localparam int SAMPLE_BITS = 24;

  localparam int COUNT_W    = 20;
  localparam int PATTERN_W  = 32;
  localparam int PAT_IDX_W  = $clog2(PATTERN_W);
  localparam int ENV_W      = 17;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int TDATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [ENV_W-1:0] Q_ONE = ENV_W'(65536);

  localparam logic [CFG_ADDR_W-1:0] REG_STEP_SAMPLES  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_PATTERN  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SMOOTH_FACTOR = 2'd2;

  typedef struct packed {
    logic [COUNT_W-1:0]   step_samples;
    logic [PATTERN_W-1:0] step_pattern;
    logic [ENV_W-1:0]     smooth_factor;
  } cfg_t;

  // stage between the sequencer and the channel lanes
  typedef struct packed {
    logic                          valid;
    logic [ENV_W-1:0]              env;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } stage_t;

endpackage

// ===== rtl/sagu_seq.sv =====
// ----------------------------------------------------------------------------
// sagu_seq
// Step counter, restart edge detect and one-pole envelope smoother.
// Holds the first pipeline register (envelope plus the request's samples).
// ----------------------------------------------------------------------------
module sagu_seq (
  input  logic                                   clk,
  input  logic                                   rst,
  input  sagu_pkg::cfg_t                         cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [sagu_pkg::SAMPLE_BITS-1:0] left_in,
  input  logic signed [sagu_pkg::SAMPLE_BITS-1:0] right_in,
  input  logic                                   restart,
  input  logic                                   down_ready,
  output sagu_pkg::stage_t                       stage
);
  import sagu_pkg::*;

  logic [COUNT_W-1:0]          sample_count;
  logic [STEP_W-1:0]           step_index;
  logic [ENV_W-1:0]            envelope;
  logic                        last_restart;

  logic [COUNT_W-1:0]          sample_count_next;
  logic [STEP_W-1:0]           step_index_next;
  logic [ENV_W-1:0]            envelope_next;

  logic                        accept;
  logic                        rise;
  logic [COUNT_W-1:0]          len;
  logic [COUNT_W-1:0]          cnt_base;
  logic [COUNT_W-1:0]          cnt_inc;
  logic [STEP_W-1:0]           idx_base;
  logic [STEP_W+PAT_IDX_W-1:0] idx_ext;
  logic                        gate_on;
  logic [ENV_W-1:0]            f;
  logic [ENV_W-1:0]            one_minus_f;
  logic [2*ENV_W-1:0]          prod;
  logic [ENV_W+1:0]            env_sum;

  assign in_ready = !stage.valid || down_ready;
  assign accept   = in_valid && in_ready;
  assign rise     = restart && !last_restart;

  // step counter; zero length behaves as one
  always_comb begin
    len      = (cfg.step_samples == '0) ? COUNT_W'(1) : cfg.step_samples;
    cnt_base = rise ? '0 : sample_count;
    idx_base = rise ? '0 : step_index;
    cnt_inc  = cnt_base + COUNT_W'(1);
    if (cnt_inc >= len) begin
      sample_count_next = '0;
      step_index_next   = (idx_base == STEP_W'(STEP_COUNT - 1)) ? '0
                                                                : idx_base + STEP_W'(1);
    end else begin
      sample_count_next = cnt_inc;
      step_index_next   = idx_base;
    end
  end

  // steps past the pattern width read as gate off
  always_comb begin
    idx_ext = (STEP_W+PAT_IDX_W)'(step_index_next);
    gate_on = (idx_ext < (STEP_W+PAT_IDX_W)'(PATTERN_W)) &&
              cfg.step_pattern[idx_ext[PAT_IDX_W-1:0]];
  end

  // env = (env*(1-f) + gate*f*1.0) >> 16; f*1.0 has no low bits
  always_comb begin
    f             = (cfg.smooth_factor > Q_ONE) ? Q_ONE : cfg.smooth_factor;
    one_minus_f   = Q_ONE - f;
    prod          = (2*ENV_W)'(envelope) * (2*ENV_W)'(one_minus_f);
    env_sum       = (ENV_W+2)'(prod[2*ENV_W-1:16]) + (gate_on ? (ENV_W+2)'(f) : '0);
    envelope_next = (env_sum > (ENV_W+2)'(Q_ONE)) ? Q_ONE : env_sum[ENV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      step_index   <= '0;
      envelope     <= '0;
      last_restart <= 1'b0;
      stage.valid  <= 1'b0;
    end else begin
      if (accept) begin
        sample_count <= sample_count_next;
        step_index   <= step_index_next;
        envelope     <= envelope_next;
        last_restart <= restart;
        stage.valid  <= 1'b1;
        stage.env    <= envelope_next;
        stage.left   <= left_in;
        stage.right  <= right_in;
      end else if (down_ready) begin
        stage.valid  <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/sagu_lane.sv =====
// ----------------------------------------------------------------------------
// sagu_lane
// One channel lane: sample times Q16 envelope, low 16 bits dropped.
// ----------------------------------------------------------------------------
module sagu_lane (
  input  logic signed [sagu_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [sagu_pkg::ENV_W-1:0]              env,
  output logic signed [sagu_pkg::SAMPLE_BITS-1:0] gated
);
  import sagu_pkg::*;

  logic signed [SAMPLE_BITS+ENV_W:0] prod;

  // arithmetic shift floors toward minus infinity
  assign prod  = (SAMPLE_BITS+ENV_W+1)'(sample) *
                 (SAMPLE_BITS+ENV_W+1)'($signed({1'b0, env}));
  assign gated = prod[SAMPLE_BITS+15:16];

endmodule

// ===== rtl/sagu_merge.sv =====
// ----------------------------------------------------------------------------
// sagu_merge
// Joins both lane results into the output register of the result stream.
// ----------------------------------------------------------------------------
module sagu_merge (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [sagu_pkg::SAMPLE_BITS-1:0] left_gated,
  input  logic signed [sagu_pkg::SAMPLE_BITS-1:0] right_gated,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [sagu_pkg::TDATA_W-1:0]           out_data
);
  import sagu_pkg::*;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= TDATA_W'({right_gated, left_gated});
    end
  end

endmodule

// ===== rtl/step_sequenced_audio_gate_unit.sv =====
// ----------------------------------------------------------------------------
// step_sequenced_audio_gate_unit
// Stereo gate driven by a 32-step on/off pattern with a smoothed envelope.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload                                  Handshake
// s_*       in   tdata: left_in, right_in; tuser: restart tvalid/tready
// m_*       out  tdata: left_out, right_out               tvalid/tready
// cfg_*     in   addr 0 step_samples, 1 step_pattern,     cfg_we, no wait
//                2 smooth_factor
//
// Pipeline: an accepted request is registered in the stage one register and moves
// on to the output register, which raises m_tvalid, once that register is free;
// one request per cycle is sustained while m_tready stays high. Stage one is the
// envelope multiply in the sequencer, stage two the per-channel lane multiplies
// into the output reg.
// Reset: synchronous rst clears counter, step, envelope, restart history and
// both valid flags; config returns to 7200 / all ones / 1.0.
// Stalls: with m_tready low both stages fill, then s_tready drops.
// ----------------------------------------------------------------------------
module step_sequenced_audio_gate_unit (
  input  logic                                clk,
  input  logic                                rst,
  // stream in
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sagu_pkg::TDATA_W-1:0]        s_tdata,   // [23:0] left_in, [47:24] right_in
  input  logic                                s_tuser,   // [0] restart
  // stream out
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sagu_pkg::TDATA_W-1:0]        m_tdata,   // [23:0] left_out, [47:24] right_out
  // register writes
  input  logic                                cfg_we,
  input  logic [sagu_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sagu_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sagu_pkg::*;

  cfg_t                          cfg;
  stage_t                        stage;
  logic                          merge_ready;
  logic signed [SAMPLE_BITS-1:0] left_gated;
  logic signed [SAMPLE_BITS-1:0] right_gated;

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_samples  <= COUNT_W'(7200);
      cfg.step_pattern  <= '1;
      cfg.smooth_factor <= Q_ONE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STEP_SAMPLES:  cfg.step_samples  <= cfg_data[COUNT_W-1:0];
        REG_STEP_PATTERN:  cfg.step_pattern  <= cfg_data[PATTERN_W-1:0];
        REG_SMOOTH_FACTOR: cfg.smooth_factor <= cfg_data[ENV_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and envelope (stage one)
  sagu_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .left_in    (s_tdata[SAMPLE_BITS-1:0]),
    .right_in   (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .restart    (s_tuser),
    .down_ready (merge_ready),
    .stage      (stage)
  );

  // one lane per channel
  sagu_lane u_lane_left (
    .sample (stage.left),
    .env    (stage.env),
    .gated  (left_gated)
  );

  sagu_lane u_lane_right (
    .sample (stage.right),
    .env    (stage.env),
    .gated  (right_gated)
  );

  // merge and output register (stage two)
  sagu_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (stage.valid),
    .in_ready    (merge_ready),
    .left_gated  (left_gated),
    .right_gated (right_gated),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (m_tdata)
  );

  // envelope stays within unity gain
  assert property (@(posedge clk) disable iff (rst) !stage.valid || stage.env <= Q_ONE)
    else $error("envelope above unity");

  // back pressure only when both stages hold a request
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> (stage.valid && m_tvalid))
    else $error("input stalled with a free stage");

  // an accepted request lands in stage one
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> stage.valid)
    else $error("accepted request lost");

endmodule
